/* rtl/qsec_pkg.sv */
// Shared constants and types for the saturating exponential cap transform.
package qsec_pkg;

	localparam int TAYLOR_TERMS = 12;
	localparam int KW           = $clog2(TAYLOR_TERMS + 1);

	localparam logic [32:0] Q_ONE          = 33'h1_0000_0000;
	localparam logic [31:0] EXP_NEG_ONE_RST = 32'd1580030169;

	localparam logic REG_EXP_NEG_ONE = 1'b0;

	typedef struct packed {
		logic        start;
		logic        wide;    // 1: 64 quotient bits, 0: 32
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] init;    // starting partial remainder, below den
	} div_req_t;

endpackage

/* rtl/qsec_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divide steps.
module qsec_div
	import qsec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [63:0] quo,
	output logic [63:0] rem
);

	logic [64:0] rem_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [64:0] trial;
	logic        fits;

	assign trial = {rem_q[63:0], num_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.wide ? 7'd64 : 7'd32;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.init};
			num_q <= req.wide ? req.num : {req.num[31:0], 32'd0};
			den_q <= req.den;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[63:0];

endmodule

/* rtl/qsec_mul.sv */
// Registered 33x33 multiplier shared by all product steps.
module qsec_mul
	import qsec_pkg::*;
(
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [65:0] prod
);

	logic [65:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {33'd0, a} * {33'd0, b};
	end

	assign prod = prod_q;

endmodule

/* rtl/qsec_core.sv */
// Sequencer: integer split, fraction, decay power, Taylor series, cap scaling.
module qsec_core
	import qsec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] t_val,
	input  logic [63:0] t_cap,
	input  logic [31:0] ratio,
	output logic        idle,
	output logic        res_valid,
	input  logic        res_take,
	output logic [63:0] res_eff,
	output logic        res_bad,
	output div_req_t    div_req,
	input  logic        div_done,
	input  logic [63:0] div_quo,
	input  logic [63:0] div_rem,
	output logic [32:0] mul_a,
	output logic [32:0] mul_b,
	input  logic [65:0] mul_prod
);

	typedef enum logic [4:0] {
		S_IDLE, S_DW, S_MW, S_FRAC, S_PINIT, S_PLOOP, S_PK, S_PM, S_PSUB, S_PUPD,
		S_SINIT, S_SSTEP, S_SDIV, S_SUPD, S_EFIN, S_EPROD, S_XCHK, S_HI, S_LO, S_DONE
	} state_t;

	state_t      state_q, nxt_q;
	div_req_t    req_q;
	logic [32:0] a_q, b_q;
	logic [63:0] cap_q, n_q, left_q, hi_q, res_q;
	logic [31:0] f_q, acc_q;
	logic [32:0] c_q, k_q, m_q, s_q, pd_q, x_q;
	logic [KW-1:0] kk_q;
	logic        bad_q;

	logic [32:0] k_w;
	logic [63:0] mcl_w;

	assign k_w   = {1'b0, mul_prod[63:32]} + {32'd0, |mul_prod[31:0]};
	assign mcl_w = (div_quo > left_q) ? left_q : div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nxt_q   <= S_IDLE;
			req_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			cap_q   <= '0;
			n_q     <= '0;
			left_q  <= '0;
			hi_q    <= '0;
			res_q   <= '0;
			f_q     <= '0;
			acc_q   <= '0;
			c_q     <= '0;
			k_q     <= '0;
			m_q     <= '0;
			s_q     <= '0;
			pd_q    <= '0;
			x_q     <= '0;
			kk_q    <= '0;
			bad_q   <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cap_q <= t_cap;
						if (t_cap == '0) begin
							res_q   <= '0;
							bad_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							bad_q   <= 1'b0;
							req_q   <= '{start: 1'b1, wide: 1'b1, num: t_val, den: t_cap,
								init: 64'd0};
							nxt_q   <= S_FRAC;
							state_q <= S_DW;
						end
					end
				end
				S_DW: begin
					if (div_done) state_q <= nxt_q;
				end
				S_MW: state_q <= nxt_q;
				S_FRAC: begin
					n_q     <= div_quo;
					req_q   <= '{start: 1'b1, wide: 1'b0, num: 64'd0, den: cap_q,
						init: div_rem};
					nxt_q   <= S_PINIT;
					state_q <= S_DW;
				end
				S_PINIT: begin
					f_q <= div_quo[31:0];
					if (n_q == '0) begin
						pd_q    <= Q_ONE;
						state_q <= S_SINIT;
					end else begin
						acc_q   <= ratio;
						left_q  <= n_q - 64'd1;
						c_q     <= Q_ONE - {1'b0, ratio};
						state_q <= S_PLOOP;
					end
				end
				S_PLOOP: begin
					if (acc_q == '0 || left_q == '0) begin
						pd_q    <= {1'b0, acc_q};
						state_q <= S_SINIT;
					end else begin
						a_q     <= {1'b0, acc_q};
						b_q     <= c_q;
						nxt_q   <= S_PK;
						state_q <= S_MW;
					end
				end
				S_PK: begin
					// k = ceil(acc*c / 2^32); steps with equal k run in one group
					k_q     <= k_w;
					req_q   <= '{start: 1'b1, wide: 1'b1,
						num: {k_w[31:0] - 32'd1, 32'd0}, den: {31'd0, c_q}, init: 64'd0};
					nxt_q   <= S_PM;
					state_q <= S_DW;
				end
				S_PM: begin
					req_q   <= '{start: 1'b1, wide: 1'b1,
						num: {32'd0, acc_q} - div_quo + {31'd0, k_q} - 64'd1,
						den: {31'd0, k_q}, init: 64'd0};
					nxt_q   <= S_PSUB;
					state_q <= S_DW;
				end
				S_PSUB: begin
					m_q     <= mcl_w[32:0];
					a_q     <= mcl_w[32:0];
					b_q     <= k_q;
					nxt_q   <= S_PUPD;
					state_q <= S_MW;
				end
				S_PUPD: begin
					acc_q   <= acc_q - mul_prod[31:0];
					left_q  <= left_q - {31'd0, m_q};
					state_q <= S_PLOOP;
				end
				S_SINIT: begin
					s_q     <= Q_ONE;
					kk_q    <= KW'(TAYLOR_TERMS);
					state_q <= S_SSTEP;
				end
				S_SSTEP: begin
					if (kk_q == '0) begin
						state_q <= S_EFIN;
					end else if (s_q[32]) begin
						req_q   <= '{start: 1'b1, wide: 1'b0, num: {32'd0, f_q},
							den: {{(64-KW){1'b0}}, kk_q}, init: 64'd0};
						nxt_q   <= S_SUPD;
						state_q <= S_DW;
					end else begin
						a_q     <= {1'b0, f_q};
						b_q     <= s_q;
						nxt_q   <= S_SDIV;
						state_q <= S_MW;
					end
				end
				S_SDIV: begin
					req_q   <= '{start: 1'b1, wide: 1'b0, num: {32'd0, mul_prod[63:32]},
						den: {{(64-KW){1'b0}}, kk_q}, init: 64'd0};
					nxt_q   <= S_SUPD;
					state_q <= S_DW;
				end
				S_SUPD: begin
					s_q     <= Q_ONE - {1'b0, div_quo[31:0]};
					kk_q    <= kk_q - KW'(1);
					state_q <= S_SSTEP;
				end
				S_EFIN: begin
					if (pd_q[32]) begin
						x_q     <= Q_ONE - s_q;
						state_q <= S_XCHK;
					end else if (s_q[32]) begin
						x_q     <= Q_ONE - pd_q;
						state_q <= S_XCHK;
					end else begin
						a_q     <= pd_q;
						b_q     <= s_q;
						nxt_q   <= S_EPROD;
						state_q <= S_MW;
					end
				end
				S_EPROD: begin
					x_q     <= Q_ONE - {1'b0, mul_prod[63:32]};
					state_q <= S_XCHK;
				end
				S_XCHK: begin
					if (x_q[32]) begin
						res_q   <= cap_q;
						state_q <= S_DONE;
					end else begin
						a_q     <= {1'b0, cap_q[63:32]};
						b_q     <= x_q;
						nxt_q   <= S_HI;
						state_q <= S_MW;
					end
				end
				S_HI: begin
					hi_q    <= mul_prod[63:0];
					a_q     <= {1'b0, cap_q[31:0]};
					b_q     <= x_q;
					nxt_q   <= S_LO;
					state_q <= S_MW;
				end
				S_LO: begin
					res_q   <= hi_q + {32'd0, mul_prod[63:32]};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res_eff   = res_q;
	assign res_bad   = bad_q;
	assign div_req   = req_q;
	assign mul_a     = a_q;
	assign mul_b     = b_q;

endmodule

/* rtl/q32_saturating_exp_cap_transform.sv */
// Top level: cap transform t_eff = cap * (1 - exp(-t/cap)), q32, APB ratio register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata = {t_cap, t_val}
//  m_      | out | m_tvalid/m_tready  | m_tdata = t_eff, m_tuser = bad_arg
//  apb     | in  | psel/penable/pready| reg 0 @ 0x0: exp_neg_one_q32
//
// Request time grows with each group of equal decay steps and each Taylor term,
// set by the one-bit-per-cycle divider.
// A zero cap skips the arithmetic. Reset clears control, ratio -> exp(-1).
// One request in flight; the next is taken once the result sits in the
// output register, which holds it under m_tready low.
module q32_saturating_exp_cap_transform
	import qsec_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // [63:0] t_val, [127:64] t_cap
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // [63:0] t_eff
	output logic [0:0]   m_tuser,   // [0] bad_arg
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [31:0] ratio_q;
	logic        idle, res_valid, res_take, res_bad;
	logic [63:0] res_eff;
	logic        mv_q;
	logic [63:0] mdata_q;
	logic        muser_q;
	div_req_t    div_req;
	logic        div_done;
	logic [63:0] div_quo, div_rem;
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_prod;

	// config register; word index is paddr[2]
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EXP_NEG_ONE) ? ratio_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= EXP_NEG_ONE_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXP_NEG_ONE) begin
			ratio_q <= pwdata;
		end
	end

	assign s_tready = idle;

	// result waits here so the core can go idle for the next request
	assign res_take = res_valid && (!mv_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (res_take) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			mdata_q <= res_eff;
			muser_q <= res_bad;
		end
	end

	assign m_tvalid   = mv_q;
	assign m_tdata    = mdata_q;
	assign m_tuser[0] = muser_q;

	qsec_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && s_tready),
		.t_val     (s_tdata[63:0]),
		.t_cap     (s_tdata[127:64]),
		.ratio     (ratio_q),
		.idle      (idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_eff   (res_eff),
		.res_bad   (res_bad),
		.div_req   (div_req),
		.div_done  (div_done),
		.div_quo   (div_quo),
		.div_rem   (div_rem),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_prod  (mul_prod)
	);

	qsec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	qsec_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

endmodule

/* rtl/qsec_chk.sv */
// Port-level checks for the cap transform, bound to the top level.
module qsec_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [0:0]   m_tuser,
	input logic         pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
		else $error("zero cap gave non-zero result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind q32_saturating_exp_cap_transform qsec_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

/* sim/q32_saturating_exp_cap_transform_test.sv */
// Testbench for the q32 saturating exponential cap transform: predicted results vs block output.
`timescale 1ns / 100ps

module q32_saturating_exp_cap_transform_test;
	import qsec_pkg::*;

	localparam logic [2:0] ADDR_EXP_NEG_ONE = {REG_EXP_NEG_ONE, 2'b00};
	localparam int         N_RANDOM         = 1030;
	localparam longint     ONE_Q            = 64'h1_0000_0000;

	// Expected transform result for one request
	typedef struct packed {
		logic [63:0] t_eff;
		logic        bad_arg;
	} cap_result_t;

	// Predictor of the transform, keeps its own copy of the ratio register
	class cap_transform_board;
		logic [31:0]  ratio;
		cap_result_t  pending[$];
		int           errors;

		function new();
			ratio  = EXP_NEG_ONE_RST;
			errors = 0;
		endfunction

		function logic [63:0] qm(logic [63:0] a, logic [63:0] b);
			if (a >= ONE_Q)
				return b;
			if (b >= ONE_Q)
				return a;
			return (a * b) >> 32;
		endfunction

		// ratio^n by repeated truncating multiply; runs with equal decrement grouped
		function logic [63:0] decay_pow(logic [63:0] n);
			logic [63:0] acc, left, c, prod, k, lim, m;
			if (n == 0)
				return ONE_Q;
			acc  = {32'd0, ratio};
			left = n - 1;
			c    = ONE_Q - acc;
			while (acc != 0 && left != 0) begin
				prod = acc * c;
				k    = (prod >> 32) + ((prod[31:0] != 0) ? 64'd1 : 64'd0);
				lim  = ((k - 1) << 32) / c;
				m    = (acc - lim + k - 1) / k;
				if (m > left)
					m = left;
				acc  = acc - m * k;
				left = left - m;
			end
			return acc;
		endfunction

		function logic [63:0] frac_q32(logic [63:0] a, logic [63:0] d);
			logic [63:0] q, r;
			q = 0;
			r = a;
			for (int i = 0; i < 32; i++) begin
				if (r >= d - r) begin
					r = r - (d - r);
					q = (q << 1) | 64'd1;
				end else begin
					r = r + r;
					q = q << 1;
				end
			end
			return q;
		endfunction

		function logic [63:0] taylor_exp(logic [63:0] f);
			logic [63:0] s;
			s = ONE_Q;
			for (int k = TAYLOR_TERMS; k >= 1; k--)
				s = ONE_Q - qm(f, s) / k;
			return s;
		endfunction

		function void note_request(logic [63:0] t, logic [63:0] cap);
			cap_result_t r;
			logic [63:0] e, x;
			if (cap == 0) begin
				r.t_eff   = 0;
				r.bad_arg = 1'b1;
			end else begin
				e = qm(decay_pow(t / cap), taylor_exp(frac_q32(t % cap, cap)));
				x = ONE_Q - e;
				r.bad_arg = 1'b0;
				if (x >= ONE_Q)
					r.t_eff = cap;
				else
					r.t_eff = (cap >> 32) * x + ((cap[31:0] * x) >> 32);
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [63:0] t_eff, logic bad_arg);
			cap_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result t_eff=%h bad_arg=%b", $time, t_eff, bad_arg);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want.t_eff !== t_eff) begin
				$display("%0t: t_eff expected %h actual %h", $time, want.t_eff, t_eff);
				errors++;
			end
			if (want.bad_arg !== bad_arg) begin
				$display("%0t: bad_arg expected %b actual %b", $time, want.bad_arg, bad_arg);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // [63:0] t_val, [127:64] t_cap
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;   // [63:0] t_eff
	logic [0:0]   m_tuser;   // [0] bad_arg
	logic         psel, penable, pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	cap_transform_board board;
	bit  hold_off_req;   // sender asks the receiver for a long stall

	q32_saturating_exp_cap_transform dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off_req = 1'b0;
			end
			gap = $urandom_range(3) == 0 ? 0 : $urandom_range(10);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
				@(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			m_tready <= 1'b0;
			board.check_result(m_tdata, m_tuser[0]);
		end
	end

	// Offer one request and wait for it to be taken; valid stays up when the next follows at once
	task automatic send_request(input logic [63:0] t, input logic [63:0] cap);
		int gap;
		gap = $urandom_range(2) == 0 ? 0 : $urandom_range(10);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {cap, t};
		do @(posedge clk); while (!s_tready);
		board.note_request(t, cap);
	endtask

	// Register write, idle block only
	task automatic write_ratio(input logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= ADDR_EXP_NEG_ONE;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.ratio = v;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Caps mostly small-ish so that t/cap ranges from zero to saturation
	task automatic random_request();
		logic [63:0] cap, t;
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: cap = 0;
			1, 2: cap = $urandom_range(1, 1000);
			3, 4: cap = {32'd0, $urandom()};
			default: cap = rand64() >> $urandom_range(63);
		endcase
		sel = $urandom_range(9);
		case (sel)
			0: t = rand64();
			1: t = 0;
			2, 3: t = cap * $urandom_range(0, 30) + (cap != 0 ? rand64() % cap : 0);
			default: t = cap == 0 ? rand64() :
				(cap * $urandom_range(0, 4)) + rand64() % cap;
		endcase
		send_request(t, cap);
	endtask

	initial begin
		logic [31:0] ratios[4];
		board    = new();
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		hold_off_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset ratio, field extremes, zero cap, zero and large integer part
		send_request(64'd0, 64'd0);
		send_request('1, 64'd0);
		send_request(64'd0, 64'd1);
		send_request('1, 64'd1);
		send_request('1, '1);
		send_request('1 - 1, '1);
		send_request(64'd0, '1);
		send_request(64'd5, 64'd10);
		send_request(64'd10, 64'd10);
		send_request(64'd100, 64'd10);
		send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(64'd1000, 64'd999);
		drain();

		// ratio extremes and near one: long decay runs
		ratios = '{32'hFFFF_FFFF, 32'd0, 32'hFFC0_0000, 32'h8000_0001};
		foreach (ratios[i]) begin
			write_ratio(ratios[i]);
			send_request(64'd30, 64'd1);
			send_request('1, 64'd3);
			send_request(64'd12345, 64'd100);
			drain();
		end
		write_ratio(EXP_NEG_ONE_RST);

		// long receiver stall while requests keep coming
		hold_off_req = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				drain();
				// ratio kept clear of one so saturating requests stay short
				write_ratio($urandom_range(32'hC000_0000));
			end
			random_request();
		end
		drain();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#500ms;
		$display("FAILURE");
		$finish;
	end

endmodule

/* files.f */
rtl/qsec_pkg.sv
rtl/qsec_div.sv
rtl/qsec_mul.sv
rtl/qsec_core.sv
rtl/q32_saturating_exp_cap_transform.sv
rtl/qsec_chk.sv
sim/q32_saturating_exp_cap_transform_test.sv
